FILE: design/baro_sensor_compensation_unit_defines.svh
// Assertion macros shared by the barometer compensation unit's RTL files.
// Each file that asserts includes this header; it depends on nothing else.
// A design that uses them must have signals named clk and arst_n in scope.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BSC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BSC_ASSERT_IMP(label, ante, cons, msg)
`define BSC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: design/bsc_pkg.sv
// Package of the barometer compensation unit: widths, register indexes, reset values,
// sequencer step codes, the controller/datapath structs and small arithmetic helpers.
// It depends on nothing.
package bsc_pkg;

	localparam int RAW_W     = 19;
	localparam int VAL_W     = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int OSS_W     = 2;
	localparam int DW        = 64;
	localparam int MUL_AW    = 50;
	localparam int MUL_BW    = 33;
	localparam int MUL_SPLIT = 25;
	localparam int DIV_W     = 62;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int STEP_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

	localparam logic [CFG_W-1:0] RST_AC1_AC2 = 32'd540080980;
	localparam logic [CFG_W-1:0] RST_AC3_AC4 = 32'd3331031184;
	localparam logic [CFG_W-1:0] RST_AC5_AC6 = 32'd1635729511;
	localparam logic [CFG_W-1:0] RST_B1_B2   = 32'd426967088;
	localparam logic [CFG_W-1:0] RST_MC_MD   = 32'd3522562845;
	localparam logic [OSS_W-1:0] RST_OSS     = 2'd0;

	localparam logic [STEP_W-1:0] STEP_T_X1  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_T_B5  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_P_SQ  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_P_X1A = 4'd3;
	localparam logic [STEP_W-1:0] STEP_P_B3  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_P_X1B = 4'd5;
	localparam logic [STEP_W-1:0] STEP_P_X3  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_P_B4  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_P_B7  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_P_DIV = 4'd9;
	localparam logic [STEP_W-1:0] STEP_P_QQ  = 4'd10;
	localparam logic [STEP_W-1:0] STEP_P_TH  = 4'd11;
	localparam logic [STEP_W-1:0] STEP_P_TL  = 4'd12;
	localparam logic [STEP_W-1:0] STEP_P_FIN = 4'd13;

	localparam logic signed [DW-1:0] VAL_MAX_W = 64'sd2147483647;
	localparam logic signed [DW-1:0] VAL_NMX_W = -64'sd2147483647;
	localparam logic signed [DW-1:0] VAL_MIN_W = -64'sd2147483648;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [OSS_W-1:0]   oss;
	} cal_t;

	typedef struct packed {
		logic              accept;
		logic              mul_lo;
		logic              mul_hi;
		logic              div_start;
		logic              wb;
		logic              out_load;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic fin;
		logic div_done;
	} dp_stat_t;

	function automatic logic signed [DW-1:0] tdiv_pow2(input logic signed [DW-1:0] x,
		input logic [5:0] k);
		logic signed [DW-1:0] bias;
		bias = x[DW-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

	function automatic logic [VAL_W-1:0] sat32(input logic signed [DW-1:0] x);
		if (x > VAL_MAX_W)
			return VAL_MAX_W[VAL_W-1:0];
		if (x < VAL_MIN_W)
			return VAL_MIN_W[VAL_W-1:0];
		return x[VAL_W-1:0];
	endfunction

	function automatic logic [15:0] press_factor(input logic [OSS_W-1:0] oss);
		case (oss)
			2'd0:    return 16'd50000;
			2'd1:    return 16'd25000;
			2'd2:    return 16'd12500;
			default: return 16'd6250;
		endcase
	endfunction

	function automatic logic is_div_step(input logic [STEP_W-1:0] step);
		return (step == STEP_T_B5) || (step == STEP_P_DIV);
	endfunction

endpackage

FILE: design/bsc_div.sv
// Iterative signed divider of the compensation datapath, truncating toward zero.
// Restoring, one quotient bit a cycle; depends on bsc_pkg and the assertion macros.
`include "baro_sensor_compensation_unit_defines.svh"

module bsc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [bsc_pkg::DW-1:0]   dividend,
	input  logic signed [bsc_pkg::DW-1:0]   divisor,
	output logic                            done,
	output logic signed [bsc_pkg::DW-1:0]   quotient
);
	import bsc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DW-1:0]        n_abs;
	logic [DW-1:0]        d_abs;
	logic [DIV_W:0]       rem_sh;
	logic [DIV_W+1:0]     diff;
	logic                 ge;

	assign n_abs  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	assign d_abs  = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = !diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1] ^ divisor[DW-1];
			den_q <= d_abs[DIV_W-1:0];
			quo_q <= n_abs[DIV_W-1:0];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(DW'(quo_q)) : $signed(DW'(quo_q));

	`BSC_ASSERT_IMP(a_div_no_restart, start, !busy_q, "divider started while busy")
	`BSC_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while still iterating")

endmodule

FILE: design/bsc_dp.sv
// Datapath of the compensation unit: operand selection, the shared two-pass multiplier,
// the divider instance, intermediate and result registers. Depends on bsc_pkg and bsc_div.
module bsc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsc_pkg::cal_t                     cal,
	input  bsc_pkg::dp_cmd_t                  dp_cmd,
	output bsc_pkg::dp_stat_t                 stat,
	input  logic                              cmd,
	input  logic [bsc_pkg::RAW_W-1:0]         raw_value,
	output logic                              kind,
	output logic signed [bsc_pkg::VAL_W-1:0]  value,
	output logic                              div_error
);
	import bsc_pkg::*;

	logic                                   cmd_q;
	logic [RAW_W-1:0]                       raw_q;
	logic signed [VAL_W-1:0]                temp_term_q;
	logic signed [DW-1:0]                   acc_q;
	logic signed [DW-1:0]                   sq_q;
	logic signed [DW-1:0]                   b3_q;
	logic signed [DW-1:0]                   b4_q;
	logic signed [DW-1:0]                   b7_q;
	logic signed [DW-1:0]                   p_q;
	logic signed [DW-1:0]                   qq_q;
	logic signed [DW-1:0]                   t_q;
	logic signed [DW-1:0]                   prod_q;
	logic [30:0]                            mag_q;
	logic signed [VAL_W-1:0]                res_val_q;
	logic                                   res_err_q;
	logic signed [MUL_SPLIT+MUL_BW:0]       lo_s1;
	logic signed [MUL_AW-MUL_SPLIT+MUL_BW-1:0] hi_prod;
	logic signed [MUL_AW-1:0]               mul_a;
	logic signed [MUL_BW-1:0]               mul_b;

	logic signed [DW-1:0] ac1_w, ac2_w, ac3_w, ac4_w, ac5_w, ac6_w;
	logic signed [DW-1:0] b1_w, b2_w, mc_w, md_w, raw_w, b5_w, b6_w;
	logic signed [DW-1:0] div_num, div_den, quotient;
	logic signed [DW-1:0] b5_new, p_new, q8, q8_abs, fin_sum, fin_p;
	logic                 div_done;
	logic                 dz;
	logic                 ovf;

	assign ac1_w = DW'(cal.ac1);
	assign ac2_w = DW'(cal.ac2);
	assign ac3_w = DW'(cal.ac3);
	assign ac4_w = $signed(DW'(cal.ac4));
	assign ac5_w = $signed(DW'(cal.ac5));
	assign ac6_w = $signed(DW'(cal.ac6));
	assign b1_w  = DW'(cal.b1);
	assign b2_w  = DW'(cal.b2);
	assign mc_w  = DW'(cal.mc);
	assign md_w  = DW'(cal.md);
	assign raw_w = $signed(DW'(raw_q));
	assign b5_w  = DW'(temp_term_q);
	assign b6_w  = b5_w - 64'sd4000;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (dp_cmd.step)
			STEP_T_X1: begin
				mul_a = MUL_AW'(raw_w - ac6_w);
				mul_b = MUL_BW'(ac5_w);
			end
			STEP_P_SQ: begin
				mul_a = MUL_AW'(b6_w);
				mul_b = MUL_BW'(b6_w);
			end
			STEP_P_X1A: begin
				mul_a = MUL_AW'(sq_q);
				mul_b = MUL_BW'(b2_w);
			end
			STEP_P_B3: begin
				mul_a = MUL_AW'(b6_w);
				mul_b = MUL_BW'(ac2_w);
			end
			STEP_P_X1B: begin
				mul_a = MUL_AW'(b6_w);
				mul_b = MUL_BW'(ac3_w);
			end
			STEP_P_X3: begin
				mul_a = MUL_AW'(sq_q);
				mul_b = MUL_BW'(b1_w);
			end
			STEP_P_B4: begin
				mul_a = MUL_AW'(acc_q + 64'sd32768);
				mul_b = MUL_BW'(ac4_w);
			end
			STEP_P_B7: begin
				mul_a = MUL_AW'(raw_w - b3_q);
				mul_b = $signed(MUL_BW'(press_factor(cal.oss)));
			end
			STEP_P_QQ: begin
				mul_a = $signed(MUL_AW'(mag_q));
				mul_b = $signed(MUL_BW'(mag_q));
			end
			STEP_P_TH: begin
				mul_a = MUL_AW'(qq_q >>> 16);
				mul_b = MUL_BW'(64'sd3038);
			end
			STEP_P_TL: begin
				mul_a = MUL_AW'(qq_q & 64'sd65535);
				mul_b = MUL_BW'(64'sd3038);
			end
			STEP_P_FIN: begin
				mul_a = MUL_AW'(p_q);
				mul_b = MUL_BW'(-64'sd7357);
			end
			default: ;
		endcase
	end

	assign hi_prod = $signed(mul_a[MUL_AW-1:MUL_SPLIT]) * mul_b;

	always_ff @(posedge clk) begin
		if (dp_cmd.mul_lo)
			lo_s1 <= $signed({1'b0, mul_a[MUL_SPLIT-1:0]}) * mul_b;
		if (dp_cmd.mul_hi)
			prod_q <= (DW'(hi_prod) <<< MUL_SPLIT) + DW'(lo_s1);
	end

	assign div_num = (dp_cmd.step == STEP_T_B5) ? (mc_w <<< 11) : b7_q;
	assign div_den = (dp_cmd.step == STEP_T_B5) ? (acc_q + md_w) : b4_q;
	assign dz      = (div_den == 64'sd0);

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dp_cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quotient)
	);

	assign b5_new  = acc_q + quotient;
	assign p_new   = quotient <<< 1;
	assign q8      = tdiv_pow2(p_new, 6'd8);
	assign q8_abs  = q8[DW-1] ? -q8 : q8;
	assign ovf     = (q8 > VAL_MAX_W) || (q8 < VAL_NMX_W);
	assign fin_sum = t_q + tdiv_pow2(prod_q, 6'd16) + 64'sd3791;
	assign fin_p   = p_q + tdiv_pow2(fin_sum, 6'd4);

	assign stat.div_done = div_done;
	assign stat.fin      = (dp_cmd.step == STEP_T_B5) || (dp_cmd.step == STEP_P_FIN) ||
		((dp_cmd.step == STEP_P_DIV) && (dz || ovf));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_term_q <= '0;
		end else if (dp_cmd.wb && (dp_cmd.step == STEP_T_B5) && !dz) begin
			temp_term_q <= b5_new[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.accept) begin
			cmd_q <= cmd;
			raw_q <= raw_value;
		end
		if (dp_cmd.wb) begin
			unique case (dp_cmd.step)
				STEP_T_X1:  acc_q <= tdiv_pow2(prod_q, 6'd15);
				STEP_T_B5: begin
					res_err_q <= dz;
					res_val_q <= dz ? '0 :
						VAL_W'(tdiv_pow2(b5_new + 64'sd8, 6'd4));
				end
				STEP_P_SQ:  sq_q  <= tdiv_pow2(prod_q, 6'd12);
				STEP_P_X1A: acc_q <= tdiv_pow2(prod_q, 6'd11);
				STEP_P_B3:  b3_q  <= tdiv_pow2((((ac1_w <<< 2) + acc_q +
					tdiv_pow2(prod_q, 6'd11)) <<< cal.oss) + 64'sd2, 6'd2);
				STEP_P_X1B: acc_q <= tdiv_pow2(prod_q, 6'd13);
				STEP_P_X3:  acc_q <= tdiv_pow2(acc_q + tdiv_pow2(prod_q, 6'd16) + 64'sd2, 6'd2);
				STEP_P_B4:  b4_q  <= tdiv_pow2(prod_q, 6'd15);
				STEP_P_B7:  b7_q  <= prod_q;
				STEP_P_DIV: begin
					p_q       <= p_new;
					mag_q     <= q8_abs[30:0];
					res_err_q <= dz;
					res_val_q <= dz ? '0 : VAL_MAX_W[VAL_W-1:0];
				end
				STEP_P_QQ:  qq_q  <= prod_q;
				STEP_P_TH:  t_q   <= prod_q;
				STEP_P_TL:  t_q   <= t_q + (prod_q >>> 16);
				STEP_P_FIN: begin
					res_val_q <= sat32(fin_p);
					res_err_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (dp_cmd.out_load) begin
			kind      <= cmd_q;
			value     <= res_val_q;
			div_error <= res_err_q;
		end
	end

endmodule

FILE: design/bsc_ctrl.sv
// Controller of the compensation unit: input and output handshakes and the step sequencer
// that drives the datapath. Depends on bsc_pkg and the assertion macros.
`include "baro_sensor_compensation_unit_defines.svh"

module bsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output bsc_pkg::dp_cmd_t  dp_cmd,
	input  bsc_pkg::dp_stat_t stat
);
	import bsc_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL_LO  = 3'd1;
	localparam logic [2:0] ST_MUL_HI  = 3'd2;
	localparam logic [2:0] ST_DIV_GO  = 3'd3;
	localparam logic [2:0] ST_DIV_RUN = 3'd4;
	localparam logic [2:0] ST_WB      = 3'd5;
	localparam logic [2:0] ST_OUT     = 3'd6;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] first_step;
	logic [STEP_W-1:0] step_nxt;
	logic              out_free;

	assign first_step = cmd ? STEP_P_SQ : STEP_T_X1;
	assign step_nxt   = step_q + STEP_W'(1);
	assign out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= first_step;
						state_q <= is_div_step(first_step) ? ST_DIV_GO : ST_MUL_LO;
					end
				end
				ST_MUL_LO:  state_q <= ST_MUL_HI;
				ST_MUL_HI:  state_q <= ST_WB;
				ST_DIV_GO:  state_q <= ST_DIV_RUN;
				ST_DIV_RUN: begin
					if (stat.div_done)
						state_q <= ST_WB;
				end
				ST_WB: begin
					if (stat.fin) begin
						state_q <= ST_OUT;
					end else begin
						step_q  <= step_nxt;
						state_q <= is_div_step(step_nxt) ? ST_DIV_GO : ST_MUL_LO;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign dp_cmd.accept    = (state_q == ST_IDLE) && in_valid;
	assign dp_cmd.mul_lo    = (state_q == ST_MUL_LO);
	assign dp_cmd.mul_hi    = (state_q == ST_MUL_HI);
	assign dp_cmd.div_start = (state_q == ST_DIV_GO);
	assign dp_cmd.wb        = (state_q == ST_WB);
	assign dp_cmd.out_load  = (state_q == ST_OUT) && out_free;
	assign dp_cmd.step      = step_q;

	`BSC_ASSERT_IMP(a_load_free, dp_cmd.out_load, !out_valid_q || out_ready, "result overwritten")
	`BSC_ASSERT_IMP(a_done_run, stat.div_done, state_q == ST_DIV_RUN, "stray divider done")
	`BSC_ASSERT_NXT(a_busy_after, dp_cmd.accept, !in_ready, "second transaction taken early")

endmodule

FILE: design/baro_sensor_compensation_unit.sv
// Barometer compensation unit: one result transaction for each input transaction.
// Temperature gives its result after one multiply (low pass, high pass, write-back) and a
// divide step of 62 iterations; pressure after eleven multiplies and one divide, or it ends
// at the divide when the divisor is zero or the pressure is out of range.
// One item is in flight at a time; the next is taken the cycle after the result is loaded.
// Reset clears control state, the stored temperature term and restores default calibration.
module baro_sensor_compensation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [bsc_pkg::RAW_W-1:0]         raw_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic signed [bsc_pkg::VAL_W-1:0]  value,
	output logic                              div_error,
	input  logic                              cfg_write,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsc_pkg::CFG_W-1:0]         cfg_data
);
	import bsc_pkg::*;

	logic [CFG_W-1:0] ac1_ac2_q;
	logic [CFG_W-1:0] ac3_ac4_q;
	logic [CFG_W-1:0] ac5_ac6_q;
	logic [CFG_W-1:0] b1_b2_q;
	logic [CFG_W-1:0] mc_md_q;
	logic [OSS_W-1:0] oss_q;
	cal_t             cal;
	dp_cmd_t          dp_cmd;
	dp_stat_t         stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= RST_AC1_AC2;
			ac3_ac4_q <= RST_AC3_AC4;
			ac5_ac6_q <= RST_AC5_AC6;
			b1_b2_q   <= RST_B1_B2;
			mc_md_q   <= RST_MC_MD;
			oss_q     <= RST_OSS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_AC1_AC2: ac1_ac2_q <= cfg_data;
				REG_AC3_AC4: ac3_ac4_q <= cfg_data;
				REG_AC5_AC6: ac5_ac6_q <= cfg_data;
				REG_B1_B2:   b1_b2_q   <= cfg_data;
				REG_MC_MD:   mc_md_q   <= cfg_data;
				REG_OSS:     oss_q     <= cfg_data[OSS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cal.ac1 = $signed(ac1_ac2_q[31:16]);
	assign cal.ac2 = $signed(ac1_ac2_q[15:0]);
	assign cal.ac3 = $signed(ac3_ac4_q[31:16]);
	assign cal.ac4 = ac3_ac4_q[15:0];
	assign cal.ac5 = ac5_ac6_q[31:16];
	assign cal.ac6 = ac5_ac6_q[15:0];
	assign cal.b1  = $signed(b1_b2_q[31:16]);
	assign cal.b2  = $signed(b1_b2_q[15:0]);
	assign cal.mc  = $signed(mc_md_q[31:16]);
	assign cal.md  = $signed(mc_md_q[15:0]);
	assign cal.oss = oss_q;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd),
		.stat      (stat)
	);

	bsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.dp_cmd    (dp_cmd),
		.stat      (stat),
		.cmd       (cmd),
		.raw_value (raw_value),
		.kind      (kind),
		.value     (value),
		.div_error (div_error)
	);

endmodule

FILE: tb/sv/tb_baro_sensor_compensation_unit.sv
// Self-checking testbench of baro_sensor_compensation_unit: directed table, then random phases.
// Every result transaction is checked in order, against an internal predictor of the
// compensation formulas or a typed row's result. Depends on bsc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_baro_sensor_compensation_unit;
	import bsc_pkg::*;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [RAW_W-1:0] RAW_MAX = 19'h7FFFF;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 250;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		int               phase;
		logic             cmd;
		logic [RAW_W-1:0] raw;
		logic             typed;
		logic [VAL_W-1:0] value;
		logic             err;
	} stim_row_t;

	typedef struct {
		logic             kind;
		logic [VAL_W-1:0] value;
		logic             err;
	} comp_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, cmd;
	logic [RAW_W-1:0] raw_value;
	logic out_valid, out_ready, kind, div_error;
	logic signed [VAL_W-1:0] value;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [CFG_W-1:0] cal_reg [0:4];
	logic [OSS_W-1:0] oss_reg;
	logic [31:0] b5_hold;
	comp_result_t pending_results [$];
	logic row_typed;
	comp_result_t row_result;
	int errors;
	int stall_cycles;
	bit tx_idle_en, rx_idle_en, hold_req;
	int hold_cnt, rx_burst;
	stim_row_t dir_rows [0:17];
	logic [CFG_W-1:0] phase_cfg [0:4][0:5];

	baro_sensor_compensation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .raw_value(raw_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .div_error(div_error),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic comp_result_t compensate(input logic c, input logic [RAW_W-1:0] r);
		comp_result_t res;
		longint raw, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, scale;
		longint x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, q, t;
		longint unsigned mag, qq;
		raw = longint'(r);
		res.kind = c;
		res.value = '0;
		res.err = 1'b0;
		if (c == CMD_TEMP) begin
			ac5 = longint'(cal_reg[REG_AC5_AC6][31:16]);
			ac6 = longint'(cal_reg[REG_AC5_AC6][15:0]);
			mc = longint'($signed(cal_reg[REG_MC_MD][31:16]));
			md = longint'($signed(cal_reg[REG_MC_MD][15:0]));
			x1 = (raw - ac6) * ac5 / 32768;
			den = x1 + md;
			if (den == 0) begin
				res.err = 1'b1;
			end else begin
				b5 = x1 + mc * 2048 / den;
				b5_hold = b5[31:0];
				b5 = (b5 + 8) / 16;
				res.value = b5[31:0];
			end
		end else begin
			ac1 = longint'($signed(cal_reg[REG_AC1_AC2][31:16]));
			ac2 = longint'($signed(cal_reg[REG_AC1_AC2][15:0]));
			ac3 = longint'($signed(cal_reg[REG_AC3_AC4][31:16]));
			ac4 = longint'(cal_reg[REG_AC3_AC4][15:0]);
			b1 = longint'($signed(cal_reg[REG_B1_B2][31:16]));
			b2 = longint'($signed(cal_reg[REG_B1_B2][15:0]));
			scale = longint'(1) << oss_reg;
			b5 = longint'($signed(b5_hold));
			b6 = b5 - 4000;
			sq = b6 * b6 / 4096;
			x1 = b2 * sq / 2048;
			x2 = ac2 * b6 / 2048;
			x3 = x1 + x2;
			b3 = ((ac1 * 4 + x3) * scale + 2) / 4;
			x1 = ac3 * b6 / 8192;
			x2 = b1 * sq / 65536;
			x3 = (x1 + x2 + 2) / 4;
			b4 = ac4 * (x3 + 32768) / 32768;
			if (b4 == 0) begin
				res.err = 1'b1;
			end else begin
				b7 = (raw - b3) * (50000 / scale);
				p = (b7 / b4) * 2;
				q = p / 256;
				if (q > 64'sd2147483647 || q < -64'sd2147483647) begin
					res.value = 32'h7FFFFFFF;
				end else begin
					mag = (q < 0) ? longint'(-q) : longint'(q);
					qq = mag * mag;
					t = longint'((qq >> 16) * 3038 + (((qq & 64'hFFFF) * 3038) >> 16));
					x2 = (-7357 * p) / 65536;
					p = p + (t + x2 + 3791) / 16;
					if (p > 64'sd2147483647)
						p = 64'sd2147483647;
					else if (p < -64'sd2147483648)
						p = -64'sd2147483648;
					res.value = p[31:0];
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		comp_result_t exp_res;
		if (cfg_write) begin
			if (cfg_index == REG_OSS)
				oss_reg = cfg_data[OSS_W-1:0];
			else if (cfg_index < REG_OSS)
				cal_reg[cfg_index] = cfg_data;
		end
		if (in_valid && in_ready) begin
			exp_res = compensate(cmd, raw_value);
			if (row_typed)
				exp_res = row_result;
			pending_results.push_back(exp_res);
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (kind !== exp_res.kind) begin
					$error("kind: expected %0d, actual %0d", exp_res.kind, kind);
					errors++;
				end
				if (value !== exp_res.value) begin
					$error("value: expected %0d, actual %0d", $signed(exp_res.value), value);
					errors++;
				end
				if (div_error !== exp_res.err) begin
					$error("div_error: expected %0d, actual %0d", exp_res.err, div_error);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		hold_cnt = 0;
		rx_burst = 0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
				out_ready = 1'b0;
			end else if (rx_burst > 0) begin
				rx_burst--;
				out_ready = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				rx_burst = $urandom_range(1, 3) - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic send(input logic c, input logic [RAW_W-1:0] r, input logic typed,
		input logic [VAL_W-1:0] v, input logic e);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		raw_value = r;
		row_typed = typed;
		row_result.kind = c;
		row_result.value = v;
		row_result.err = e;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_checked(input logic c, input logic [RAW_W-1:0] r);
		send(c, r, 1'b0, '0, 1'b0);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		row_typed = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = d;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_cal(input logic [CFG_W-1:0] dflt);
		case ($urandom_range(0, 5))
			0: return dflt;
			1, 2: return dflt ^ ($urandom & 32'h00FF00FF);
			3: return $urandom;
			4: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h00000000;
			default: return $urandom_range(0, 1) ? 32'h80008000 : 32'h7FFF7FFF;
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw(input logic c);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RAW_MAX;
			2, 3, 4: return (c == CMD_TEMP) ? 19'(27898 + $urandom_range(0, 4000) - 2000)
				: 19'(23843 + $urandom_range(0, 8000) - 4000);
			default: return $urandom_range(0, 524287);
		endcase
	endfunction

	initial begin
		int prev_phase, n, k;
		in_valid = 1'b0;
		cmd = CMD_TEMP;
		raw_value = '0;
		cfg_write = 1'b0;
		cfg_index = REG_AC1_AC2;
		cfg_data = '0;
		row_typed = 1'b0;
		row_result = '{1'b0, '0, 1'b0};
		errors = 0;
		stall_cycles = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req = 1'b0;
		cal_reg[REG_AC1_AC2] = RST_AC1_AC2;
		cal_reg[REG_AC3_AC4] = RST_AC3_AC4;
		cal_reg[REG_AC5_AC6] = RST_AC5_AC6;
		cal_reg[REG_B1_B2] = RST_B1_B2;
		cal_reg[REG_MC_MD] = RST_MC_MD;
		oss_reg = RST_OSS;
		b5_hold = '0;

		phase_cfg[0] = '{RST_AC1_AC2, RST_AC3_AC4, RST_AC5_AC6, RST_B1_B2, RST_MC_MD, 0};
		phase_cfg[1] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 3};
		phase_cfg[2] = '{0, 0, 0, 0, 0, 0};
		phase_cfg[3] = '{32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000,
			32'h80008000, 1};
		phase_cfg[4] = '{32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF,
			32'h7FFF7FFF, 2};

		dir_rows = '{
			'{0, CMD_PRESS, 19'd23843, 1'b0, 32'd0, 1'b0},
			'{0, CMD_TEMP,  19'd27898, 1'b0, 32'd0, 1'b0},
			'{0, CMD_PRESS, 19'd23843, 1'b0, 32'd0, 1'b0},
			'{0, CMD_TEMP,  19'd0,     1'b0, 32'd0, 1'b0},
			'{0, CMD_PRESS, 19'd0,     1'b0, 32'd0, 1'b0},
			'{0, CMD_TEMP,  RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{0, CMD_PRESS, RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{1, CMD_TEMP,  19'd0,     1'b0, 32'd0, 1'b0},
			'{1, CMD_PRESS, 19'd0,     1'b0, 32'd0, 1'b0},
			'{1, CMD_TEMP,  RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{1, CMD_PRESS, RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{2, CMD_TEMP,  19'd12345, 1'b1, 32'd0, 1'b1},
			'{2, CMD_PRESS, RAW_MAX,   1'b1, 32'd0, 1'b1},
			'{3, CMD_TEMP,  RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{3, CMD_PRESS, 19'd0,     1'b0, 32'd0, 1'b0},
			'{4, CMD_TEMP,  19'd0,     1'b0, 32'd0, 1'b0},
			'{4, CMD_PRESS, RAW_MAX,   1'b0, 32'd0, 1'b0},
			'{4, CMD_PRESS, 19'd65536, 1'b0, 32'd0, 1'b0}
		};

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		prev_phase = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].phase != prev_phase) begin
				settle();
				prev_phase = dir_rows[i].phase;
				for (int r = 0; r < 6; r++)
					cfg_put(r[CFG_IDX_W-1:0], phase_cfg[prev_phase][r]);
				cfg_put(REG_SPARE_LO, $urandom);
				cfg_put(REG_SPARE_HI, $urandom);
				end_writes();
			end
			send(dir_rows[i].cmd, dir_rows[i].raw, dir_rows[i].typed,
				dir_rows[i].value, dir_rows[i].err);
		end
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			cfg_put(REG_AC1_AC2, pick_cal(RST_AC1_AC2));
			cfg_put(REG_AC3_AC4, pick_cal(RST_AC3_AC4));
			cfg_put(REG_AC5_AC6, pick_cal(RST_AC5_AC6));
			cfg_put(REG_B1_B2, pick_cal(RST_B1_B2));
			cfg_put(REG_MC_MD, pick_cal(RST_MC_MD));
			cfg_put(REG_OSS, $urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0)
				cfg_put($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			end_writes();
			n = 0;
			while (n < 105) begin
				if (ph == 2 && n == 40)
					hold_req = 1'b1;
				if (ph == 4 && n == 50)
					settle();
				k = $urandom_range(0, 9);
				if (k < 7) begin
					send_checked(CMD_TEMP, pick_raw(CMD_TEMP));
					send_checked(CMD_PRESS, pick_raw(CMD_PRESS));
					n += 2;
				end else if (k == 7) begin
					send_checked(CMD_TEMP, pick_raw(CMD_TEMP));
					n++;
				end else begin
					repeat ($urandom_range(1, 3)) begin
						send_checked(CMD_PRESS, $urandom_range(0, 524287));
						n++;
					end
				end
			end
			settle();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
